FILE: design/ccmk_pkg.sv
package ccmk_pkg;

  // default sizes of the block
  localparam int unsigned LANES_DEF       = 4;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned SUM_BITS_DEF    = 48;

  // configuration port sizes
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_ADDR_BITS = 3;

  // register indexes (byte address 4 * index)
  typedef enum logic {
    REG_CONJ_MODE    = 1'b0,
    REG_ACTIVE_LANES = 1'b1
  } cfg_reg_e;

  localparam logic [2:0] ACTIVE_LANES_RST = 3'd4;

  // pipeline control shared by all lanes
  typedef struct packed {
    logic adv;        // pipeline moves this cycle
    logic s1_valid;   // samples held in the input stage
    logic s2_valid;   // products held
    logic s3_valid;   // terms held, accumulate this cycle
    logic s3_first;   // clear accumulators before this add
    logic transpose;  // accumulate conj(v)*u
  } lane_ctrl_t;

endpackage

FILE: design/ccmk_lane.sv
module ccmk_lane #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned SUM_BITS    = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ccmk_pkg::lane_ctrl_t          ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] u_re_i,
  input  logic signed [SAMPLE_BITS-1:0] u_im_i,
  input  logic signed [SAMPLE_BITS-1:0] v_re_i,
  input  logic signed [SAMPLE_BITS-1:0] v_im_i,
  output logic signed [SUM_BITS-1:0]    re_nxt_o,
  output logic signed [SUM_BITS-1:0]    im_nxt_o,
  output logic                          sat_o
);

  localparam int unsigned PW = 2 * SAMPLE_BITS;
  localparam int unsigned TW = PW + 1;
  localparam int unsigned EW = ((SUM_BITS > TW) ? SUM_BITS : TW) + 1;

  localparam logic signed [EW-1:0] SUM_HI = {{(EW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [EW-1:0] SUM_LO = ~SUM_HI;

  logic signed [PW-1:0]       p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [TW-1:0]       term_d [2];
  logic signed [TW-1:0]       term_q [2];
  logic signed [SUM_BITS-1:0] acc_q  [2];
  logic signed [SUM_BITS-1:0] acc_d  [2];
  logic                       sat    [2];

  // partial products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv && ctrl_i.s1_valid) begin
      p_rr_q <= PW'(u_re_i) * PW'(v_re_i);
      p_ii_q <= PW'(u_im_i) * PW'(v_im_i);
      p_ri_q <= PW'(u_re_i) * PW'(v_im_i);
      p_ir_q <= PW'(u_im_i) * PW'(v_re_i);
    end
  end

  // real and imaginary terms, the transposed form negates the imaginary part
  always_comb begin
    term_d[0] = TW'(p_rr_q) + TW'(p_ii_q);
    if (ctrl_i.transpose) begin
      term_d[1] = TW'(p_ir_q) - TW'(p_ri_q);
    end else begin
      term_d[1] = TW'(p_ri_q) - TW'(p_ir_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv && ctrl_i.s2_valid) begin
      term_q[0] <= term_d[0];
      term_q[1] <= term_d[1];
    end
  end

  // saturating accumulate
  always_comb begin
    logic signed [EW-1:0] base;
    logic signed [EW-1:0] total;
    for (int i = 0; i < 2; i++) begin
      base  = ctrl_i.s3_first ? '0 : EW'(acc_q[i]);
      total = base + EW'(term_q[i]);
      if (total > SUM_HI) begin
        acc_d[i] = SUM_HI[SUM_BITS-1:0];
        sat[i]   = 1'b1;
      end else if (total < SUM_LO) begin
        acc_d[i] = SUM_LO[SUM_BITS-1:0];
        sat[i]   = 1'b1;
      end else begin
        acc_d[i] = total[SUM_BITS-1:0];
        sat[i]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
    end else if (ctrl_i.adv && ctrl_i.s3_valid) begin
      acc_q[0] <= acc_d[0];
      acc_q[1] <= acc_d[1];
    end
  end

  assign re_nxt_o = acc_d[0];
  assign im_nxt_o = acc_d[1];
  assign sat_o    = sat[0] | sat[1];

endmodule

FILE: design/complex_conj_mac_kernel_grad.sv
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  u samples, gradient, first, last
// m_axis    out  m_axis_tvalid / m_axis_tready  lane sums, saturation flag
// apb       in   psel & penable & pwrite        conjugate_mode, active_lanes
//
// one transaction per cycle is taken unless stalled; the result of the tlast transaction is
// loaded into the output register (product, term and accumulate stages follow the input register)
// the accumulate stage adds one term per lane each cycle it advances, which sets the rate
// reset clears accumulators, saturation flag, stage flags, output valid and config registers
// the input stalls only while a tlast item waits on a full, unaccepted output
module complex_conj_mac_kernel_grad #(
  parameter int unsigned LANES       = ccmk_pkg::LANES_DEF,
  parameter int unsigned SAMPLE_BITS = ccmk_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned SUM_BITS    = ccmk_pkg::SUM_BITS_DEF,
  localparam int unsigned IN_BITS    = (((2 * LANES + 2) * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS   = ((2 * LANES * SUM_BITS + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // stream in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // u0_re, u0_im, u1_re, ... , grad_re, grad_im (from bit 0 up)
  input  logic [IN_BITS-1:0]                   s_axis_tdata,
  // first_item
  input  logic                                 s_axis_tuser,
  input  logic                                 s_axis_tlast,
  // stream out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // sum0_re, sum0_im, sum1_re, ... (from bit 0 up)
  output logic [OUT_BITS-1:0]                  m_axis_tdata,
  // saturated
  output logic                                 m_axis_tuser,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ccmk_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [ccmk_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [ccmk_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  import ccmk_pkg::*;

  logic       conj_mode_q;
  logic [2:0] active_lanes_q;
  logic       cfg_wr;
  cfg_reg_e   cfg_sel;

  logic adv;
  logic in_acc;
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_first_q, s2_first_q, s3_first_q;
  logic s1_last_q, s2_last_q, s3_last_q;

  logic [LANES-1:0]             lane_on;
  logic signed [SAMPLE_BITS-1:0] u_re_q [LANES];
  logic signed [SAMPLE_BITS-1:0] u_im_q [LANES];
  logic signed [SAMPLE_BITS-1:0] v_re_q, v_im_q;

  lane_ctrl_t                 ctrl;
  logic signed [SUM_BITS-1:0] re_nxt [LANES];
  logic signed [SUM_BITS-1:0] im_nxt [LANES];
  logic [LANES-1:0]           lane_sat;

  logic                       ovf_q, ovf_d;
  logic                       out_load;
  logic                       out_valid_q;
  logic [SUM_BITS-1:0]        out_sum_q [2*LANES];
  logic                       out_sat_q;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conj_mode_q    <= 1'b0;
      active_lanes_q <= ACTIVE_LANES_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_CONJ_MODE:    conj_mode_q    <= pwdata[0];
        REG_ACTIVE_LANES: active_lanes_q <= pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_CONJ_MODE:    prdata = {{(CFG_DATA_BITS-1){1'b0}}, conj_mode_q};
      REG_ACTIVE_LANES: prdata = {{(CFG_DATA_BITS-3){1'b0}}, active_lanes_q};
    endcase
  end

  // stall only when a result is due and the output slot stays full
  assign adv           = !(s3_valid_q && s3_last_q && out_valid_q && !m_axis_tready);
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;

  // stage valids and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s2_first_q <= 1'b0;
      s3_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_last_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_axis_tvalid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s1_first_q <= s_axis_tuser;
      s2_first_q <= s1_first_q;
      s3_first_q <= s2_first_q;
      s1_last_q  <= s_axis_tlast;
      s2_last_q  <= s1_last_q;
      s3_last_q  <= s2_last_q;
    end
  end

  // lanes at or above active_lanes read as zero
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_on[k] = (k < int'(active_lanes_q));
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < LANES; k++) begin
        u_re_q[k] <= lane_on[k] ? s_axis_tdata[(2*k)*SAMPLE_BITS +: SAMPLE_BITS] : '0;
        u_im_q[k] <= lane_on[k] ? s_axis_tdata[(2*k+1)*SAMPLE_BITS +: SAMPLE_BITS] : '0;
      end
      v_re_q <= s_axis_tdata[(2*LANES)*SAMPLE_BITS +: SAMPLE_BITS];
      v_im_q <= s_axis_tdata[(2*LANES+1)*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // lane array
  assign ctrl.adv       = adv;
  assign ctrl.s1_valid  = s1_valid_q;
  assign ctrl.s2_valid  = s2_valid_q;
  assign ctrl.s3_valid  = s3_valid_q;
  assign ctrl.s3_first  = s3_first_q;
  assign ctrl.transpose = conj_mode_q;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    ccmk_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .SUM_BITS   (SUM_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .u_re_i  (u_re_q[k]),
      .u_im_i  (u_im_q[k]),
      .v_re_i  (v_re_q),
      .v_im_i  (v_im_q),
      .re_nxt_o(re_nxt[k]),
      .im_nxt_o(im_nxt[k]),
      .sat_o   (lane_sat[k])
    );
  end

  // sticky saturation flag
  assign ovf_d = (s3_first_q ? 1'b0 : ovf_q) | (|lane_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else if (adv && s3_valid_q) begin
      ovf_q <= ovf_d;
    end
  end

  // output register
  assign out_load = adv && s3_valid_q && s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int k = 0; k < LANES; k++) begin
        out_sum_q[2*k]   <= re_nxt[k];
        out_sum_q[2*k+1] <= im_nxt[k];
      end
      out_sat_q <= ovf_d;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int j = 0; j < 2 * LANES; j++) begin
      m_axis_tdata[j*SUM_BITS +: SUM_BITS] = out_sum_q[j];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_sat_q;

endmodule
